// ===== sv/mhnt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhnt_pkg;

  localparam int unsigned CfgDataBits = 8;
  localparam int unsigned CfgAddrBits = 2;

  localparam logic [3:0] CmdNoteOff = 4'h8;
  localparam logic [3:0] CmdNoteOn  = 4'h9;

  typedef enum logic [CfgAddrBits-1:0] {
    REG_FILTER_CHANNEL = 2'd0,
    REG_START_NOTE     = 2'd1,
    REG_KEY_COUNT      = 2'd2,
    REG_COLOR_VELOCITY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic       kind;
    logic       long_message;
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_t;

  typedef struct packed {
    logic [6:0] key_index;
    logic       set_color;
    logic       default_color;
    logic [6:0] color_velocity_out;
    logic       repaint_color;
    logic       press_changed;
    logic       pressed;
  } out_t;

  typedef struct packed {
    logic signed [4:0] filter_channel;
    logic [6:0]        start_note;
    logic [7:0]        key_count;
    logic              color_velocity;
  } cfg_t;

  // Write enables for the two counter stores.
  typedef struct packed {
    logic cnt_we;
    logic refs_we;
  } store_we_t;

endpackage

`default_nettype wire

// ===== sv/mhnt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhnt_store import mhnt_pkg::*; #(
  parameter int unsigned SLOTS      = 2048,
  parameter int unsigned NOTES      = 128,
  parameter int unsigned COUNT_BITS = 8,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned NW = (NOTES > 1) ? $clog2(NOTES) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_slot_i,
  input  wire logic [NW-1:0]         rd_note_i,
  input  wire store_we_t             we_i,
  input  wire logic [AW-1:0]         wr_slot_i,
  input  wire logic [NW-1:0]         wr_note_i,
  input  wire logic [COUNT_BITS-1:0] wr_cnt_i,
  input  wire logic [COUNT_BITS-1:0] wr_refs_i,
  output logic      [COUNT_BITS-1:0] cnt_o,
  output logic      [COUNT_BITS-1:0] refs_o
);

  logic [COUNT_BITS-1:0] cnt_mem  [SLOTS];
  logic [COUNT_BITS-1:0] refs_mem [NOTES];
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] refs_q;

  always_ff @(posedge clk_i) begin
    if (we_i.cnt_we) begin
      cnt_mem[wr_slot_i] <= wr_cnt_i;
    end
    if (rd_en_i) begin
      cnt_q <= cnt_mem[rd_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i.refs_we) begin
      refs_mem[wr_note_i] <= wr_refs_i;
    end
    if (rd_en_i) begin
      refs_q <= refs_mem[rd_note_i];
    end
  end

  assign cnt_o  = cnt_q;
  assign refs_o = refs_q;

endmodule

`default_nettype wire

// ===== sv/mhnt_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhnt_update import mhnt_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                  valid_i,
  input  wire logic [7:0]            status_i,
  input  wire logic [6:0]            note_i,
  input  wire logic [6:0]            velocity_i,
  input  wire cfg_t                  cfg_i,
  input  wire logic [COUNT_BITS-1:0] cnt_i,
  input  wire logic [COUNT_BITS-1:0] refs_i,
  output logic      [COUNT_BITS-1:0] cnt_o,
  output logic      [COUNT_BITS-1:0] refs_o,
  output store_we_t                  we_o,
  output logic                       emit_o,
  output out_t                       result_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  logic                  on;
  logic                  pass;
  logic                  changed;
  logic                  set_c;
  logic                  def_c;
  logic                  in_range;
  logic [6:0]            diff;
  logic [COUNT_BITS-1:0] refs_after;

  always_comb begin
    on   = (velocity_i != 7'd0) && (status_i[7:4] == CmdNoteOn);
    pass = cfg_i.filter_channel[4] || (cfg_i.filter_channel[3:0] == status_i[3:0]);

    cnt_o        = cnt_i;
    refs_o       = refs_i;
    we_o.cnt_we  = 1'b0;
    we_o.refs_we = 1'b0;
    changed      = 1'b0;

    if (on) begin
      if (cnt_i != CountMax) begin
        cnt_o       = cnt_i + CountOne;
        we_o.cnt_we = valid_i;
      end
      if (pass && (refs_i != CountMax)) begin
        refs_o       = refs_i + CountOne;
        we_o.refs_we = valid_i;
        changed      = (refs_i == '0);
      end
    end else if (cnt_i != '0) begin
      cnt_o       = cnt_i - CountOne;
      we_o.cnt_we = valid_i;
      if (pass && (refs_i != '0)) begin
        refs_o       = refs_i - CountOne;
        we_o.refs_we = valid_i;
        changed      = (refs_i == CountOne);
      end
    end

    refs_after = we_o.refs_we ? refs_o : refs_i;

    diff     = note_i - cfg_i.start_note;
    in_range = (note_i >= cfg_i.start_note) && ({1'b0, diff} < cfg_i.key_count);

    set_c = cfg_i.color_velocity && pass && (on || (refs_after == '0));
    def_c = set_c && !on;

    emit_o = valid_i && in_range && (set_c || changed);

    result_o.key_index          = diff;
    result_o.set_color          = set_c;
    result_o.default_color      = def_c;
    result_o.color_velocity_out = (set_c && !def_c) ? velocity_i : 7'd0;
    result_o.repaint_color      = set_c && !changed;
    result_o.press_changed      = changed;
    result_o.pressed            = changed && on;
  end

endmodule

`default_nettype wire

// ===== sv/midi_held_note_tracker_unit.sv =====
// Channel  Direction  Signals                                Handshake
// request  in         start_i, req_i (in_t), busy_o           start_i && !busy_o
// result   out        result_valid_o, result_o (out_t)        one-cycle strobe
// config   in         cfg_we_i, cfg_addr_i, cfg_wdata_i       write when cfg_we_i
//
// A message request: the accept edge reads both counters, the ST_EXEC cycle
// updates them, writes them back and registers the result, which shows in the
// following cycle while the next request may already be taken.
// Reset and the clear request zero both stores with a sweep of the CHANNELS*NOTES
// active-count entries (2048 by default), one entry per cycle; busy_o is high.
// The result side has no back pressure.
`timescale 1ns / 1ps
`default_nettype none

module midi_held_note_tracker_unit import mhnt_pkg::*; #(
  parameter int unsigned CHANNELS   = 16,
  parameter int unsigned NOTES      = 128,
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire in_t                    req_i,
  output logic                        busy_o,
  output logic                        result_valid_o,
  output out_t                        result_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgAddrBits-1:0] cfg_addr_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i
);

  localparam int unsigned SLOTS = CHANNELS * NOTES;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW    = (NOTES > 1) ? $clog2(NOTES) : 1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic [AW-1:0] sweep_q;
  logic          result_valid_q;
  out_t          result_q;
  cfg_t          cfg_q;

  logic          valid_q;
  logic [7:0]    status_q;
  logic [6:0]    note_q;
  logic [6:0]    velocity_q;
  logic [AW-1:0] slot_q;
  logic [NW-1:0] nidx_q;

  logic          accept;
  logic          req_valid;
  logic [AW-1:0] rd_slot;
  logic [NW-1:0] rd_note;

  store_we_t             store_we;
  store_we_t             upd_we;
  logic [AW-1:0]         wr_slot;
  logic [NW-1:0]         wr_note;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [COUNT_BITS-1:0] wr_refs;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] refs_rd;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0] refs_new;
  logic                  emit;
  out_t                  result_d;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Decode of the request; anything that touches no counter reads entry zero.
  always_comb begin
    req_valid = !req_i.long_message
             && ((req_i.status[7:4] == CmdNoteOn) || (req_i.status[7:4] == CmdNoteOff))
             && (32'(req_i.status[3:0]) < CHANNELS)
             && (32'(req_i.note) < NOTES);
    rd_slot = '0;
    rd_note = '0;
    if (req_valid) begin
      rd_slot = AW'(32'(req_i.status[3:0]) * NOTES + 32'(req_i.note));
      rd_note = req_i.note[NW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      valid_q    <= req_valid;
      status_q   <= req_i.status;
      note_q     <= req_i.note;
      velocity_q <= req_i.velocity;
      slot_q     <= rd_slot;
      nidx_q     <= rd_note;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_channel <= 5'sb11111;
      cfg_q.start_note     <= 7'd0;
      cfg_q.key_count      <= 8'd128;
      cfg_q.color_velocity <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_FILTER_CHANNEL: cfg_q.filter_channel <= signed'(cfg_wdata_i[4:0]);
        REG_START_NOTE:     cfg_q.start_note     <= cfg_wdata_i[6:0];
        REG_KEY_COUNT:      cfg_q.key_count      <= cfg_wdata_i;
        REG_COLOR_VELOCITY: cfg_q.color_velocity <= cfg_wdata_i[0];
      endcase
    end
  end

  mhnt_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .valid_i    (valid_q),
    .status_i   (status_q),
    .note_i     (note_q),
    .velocity_i (velocity_q),
    .cfg_i      (cfg_q),
    .cnt_i      (cnt_rd),
    .refs_i     (refs_rd),
    .cnt_o      (cnt_new),
    .refs_o     (refs_new),
    .we_o       (upd_we),
    .emit_o     (emit),
    .result_o   (result_d)
  );

  // The clearing sweep and the update share the write ports of both stores.
  always_comb begin
    store_we = '0;
    wr_slot  = slot_q;
    wr_note  = nidx_q;
    wr_cnt   = cnt_new;
    wr_refs  = refs_new;
    unique case (state_q)
      ST_SWEEP: begin
        store_we.cnt_we  = 1'b1;
        store_we.refs_we = (32'(sweep_q) < NOTES);
        wr_slot          = sweep_q;
        wr_note          = sweep_q[NW-1:0];
        wr_cnt           = '0;
        wr_refs          = '0;
      end
      ST_EXEC: store_we = upd_we;
      ST_IDLE: store_we = '0;
      default: store_we = '0;
    endcase
  end

  mhnt_store #(
    .SLOTS      (SLOTS),
    .NOTES      (NOTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_slot_i (rd_slot),
    .rd_note_i (rd_note),
    .we_i      (store_we),
    .wr_slot_i (wr_slot),
    .wr_note_i (wr_note),
    .wr_cnt_i  (wr_cnt),
    .wr_refs_i (wr_refs),
    .cnt_o     (cnt_rd),
    .refs_o    (refs_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_SWEEP;
      sweep_q        <= '0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        ST_SWEEP: begin
          if (sweep_q == AW'(SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_i.kind) begin
              state_q <= ST_SWEEP;
              sweep_q <= '0;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state_q        <= ST_IDLE;
          result_valid_q <= emit;
          result_q       <= result_d;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without an update cycle");

  a_clear_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind) |=> (state_q == ST_SWEEP && sweep_q == '0))
    else $error("clear request did not start the sweep");

  a_result_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.set_color || result_o.press_changed))
    else $error("empty result emitted");

  a_color_fields_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.set_color) |->
      (!result_o.default_color && !result_o.repaint_color
       && result_o.color_velocity_out == 7'd0))
    else $error("color fields set without a color update");

  a_pressed_needs_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.pressed) |-> result_o.press_changed)
    else $error("pressed without a press change");

endmodule

`default_nettype wire
